### sv/sprite_transparency_rle_encoder_defines.svh
// assertion macros for the sprite transparency run-length encoder
`ifndef SPRITE_TRANSPARENCY_RLE_ENCODER_DEFINES_SVH
`define SPRITE_TRANSPARENCY_RLE_ENCODER_DEFINES_SVH
`ifndef SYNTH
`define SRLE_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("srle assertion failed");
`define SRLE_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("srle forbidden condition seen");
`else
`define SRLE_ASSERT(lbl, clk, rst_n, prop)
`define SRLE_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

### sv/srle_pkg.sv
// shared constants for the sprite transparency run-length encoder
package srle_pkg;
	localparam int BLOCK_ROWS = 32;
	localparam int ADDR_W     = 25;
	localparam int SIZE_W     = 12;
	localparam int SHS_W      = 11;
	localparam int TADDR_W    = 10;
	localparam int TVAL_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam int TABLE_LAST = 1022;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLIPPED_MODE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SUB_HEADER   = 2'd3;
endpackage

### sv/srle_if.sv
// request channel interfaces for pixels in and byte writes out
interface srle_pix_if import srle_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] palette_index;
	logic       is_transparent;
	modport source (output valid, palette_index, is_transparent, input ready);
	modport sink (input valid, palette_index, is_transparent, output ready);
endinterface

interface srle_res_if import srle_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ADDR_W-1:0]   head_addr;
	logic signed [7:0]   head_value;
	logic                data_valid;
	logic [ADDR_W-1:0]   data_addr;
	logic [7:0]          data_value;
	logic                table_valid;
	logic [TADDR_W-1:0]  table_addr;
	logic [TVAL_W-1:0]   table_value;
	logic                frame_done;
	logic [ADDR_W-1:0]   end_offset;
	modport source (output valid, head_addr, head_value, data_valid, data_addr, data_value,
		table_valid, table_addr, table_value, frame_done, end_offset, input ready);
	modport sink (input valid, head_addr, head_value, data_valid, data_addr, data_value,
		table_valid, table_addr, table_value, frame_done, end_offset, output ready);
endinterface

### sv/sprite_transparency_rle_encoder.sv
// sprite transparency run-length encoder: pixels in, frame byte writes out
//
// pix carries one palette-indexed pixel per request, rows bottom-up, each row
// left to right. res carries one request per pixel: the run-control byte
// write, an optional palette byte write, an optional row-block table entry,
// the frame-done flag and the write offset after this pixel.
// cfg_we/cfg_index/cfg_data write frame_width, frame_height, clipped_mode
// and the table reserve size; write them only while no pixel is in flight.
// each result is registered and appears in the cycle after its pixel is taken.
// throughput: one pixel per cycle while res is not stalled; the run state lives in a single register
// set updated by one short pass of compares and three 25-bit adders.
// res has one output register: pix.ready stays high while that register is
// empty or being drained, so a stalled receiver holds off at most one result
// and the block stops taking pixels until it is taken.
// reset clears the row, column and run state, loads the default sizes and clears
// clipped mode; the first pixel of each frame reloads the write offset.
`include "sprite_transparency_rle_encoder_defines.svh"
module sprite_transparency_rle_encoder import srle_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	srle_pix_if.sink              pix,
	srle_res_if.source            res
);
	logic [SIZE_W-1:0] fw_q, fh_q;
	logic              clip_q;
	logic [SHS_W-1:0]  shs_q;

	logic [SIZE_W-1:0] col_q, row_q;
	logic [ADDR_W-1:0] wo_q, head_q;
	logic [7:0]        hc_q;
	logic              at_q;

	logic              acc;
	logic              first_px, open_a, open_b, opaque, at_a;
	logic [7:0]        hc_a, hc_b, hc_n;
	logic [ADDR_W-1:0] wo0, head_n, data_addr, end_n;
	logic [1:0]        inc_ab, inc_all;
	logic [SIZE_W:0]   line, col_inc, row_inc, width, height;
	logic [SIZE_W:0]   blk;
	logic [SIZE_W+1:0] entry;
	logic              tbl_hit, row_end, frame_end;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q   <= SIZE_W'(1);
			fh_q   <= SIZE_W'(1);
			clip_q <= 1'b0;
			shs_q  <= SHS_W'(10);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  fw_q   <= cfg_data[SIZE_W-1:0];
				REG_FRAME_HEIGHT: fh_q   <= cfg_data[SIZE_W-1:0];
				REG_CLIPPED_MODE: clip_q <= cfg_data[0];
				REG_SUB_HEADER:   shs_q  <= cfg_data[SHS_W-1:0];
				default: ;
			endcase
		end
	end

	assign pix.ready = !res.valid || res.ready;
	assign acc       = pix.valid && pix.ready;

	always_comb begin
		first_px = (col_q == '0) && (row_q == '0);
		open_a   = (col_q == '0);
		opaque   = !pix.is_transparent;
		if (first_px) begin
			wo0 = clip_q ? ADDR_W'(shs_q) : '0;
		end else begin
			wo0 = wo_q;
		end
		at_a = open_a ? 1'b0 : at_q;
		hc_a = open_a ? 8'd0 : hc_q;
		if (opaque) begin
			open_b = at_a || (hc_a > 8'd126);
		end else begin
			open_b = !open_a && (!at_a || (hc_a == 8'h80));
		end
		hc_b = open_b ? 8'd0 : hc_a;
		hc_n = opaque ? hc_b + 8'd1 : hc_b - 8'd1;

		inc_ab    = {1'b0, open_a} + {1'b0, open_b};
		inc_all   = inc_ab + {1'b0, opaque};
		data_addr = wo0 + ADDR_W'(inc_ab);
		end_n     = wo0 + ADDR_W'(inc_all);
		if (open_b) begin
			head_n = wo0 + ADDR_W'(open_a);
		end else if (open_a) begin
			head_n = wo0;
		end else begin
			head_n = head_q;
		end

		// row-block offset table
		line    = {1'b0, row_q} + (SIZE_W+1)'(1);
		blk     = line / (SIZE_W+1)'(BLOCK_ROWS);
		entry   = {blk, 1'b0};
		tbl_hit = open_a && clip_q && ((line % (SIZE_W+1)'(BLOCK_ROWS)) == (SIZE_W+1)'(1))
			&& (entry <= (SIZE_W+2)'(TABLE_LAST));

		width     = (fw_q == '0) ? (SIZE_W+1)'(1) : {1'b0, fw_q};
		height    = (fh_q == '0) ? (SIZE_W+1)'(1) : {1'b0, fh_q};
		col_inc   = {1'b0, col_q} + (SIZE_W+1)'(1);
		row_inc   = line;
		row_end   = col_inc >= width;
		frame_end = row_end && (row_inc >= height);
	end

	// run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			wo_q   <= '0;
			head_q <= '0;
			hc_q   <= '0;
			at_q   <= 1'b0;
		end else if (acc) begin
			wo_q   <= end_n;
			head_q <= head_n;
			hc_q   <= hc_n;
			at_q   <= !opaque;
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_inc[SIZE_W-1:0];
			end else begin
				col_q <= col_inc[SIZE_W-1:0];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.valid <= 1'b0;
		end else if (acc) begin
			res.valid <= 1'b1;
		end else if (res.ready) begin
			res.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res.head_addr   <= head_n;
			res.head_value  <= hc_n;
			res.data_valid  <= opaque;
			res.data_addr   <= opaque ? data_addr : '0;
			res.data_value  <= opaque ? pix.palette_index : 8'd0;
			res.table_valid <= tbl_hit;
			res.table_addr  <= tbl_hit ? entry[TADDR_W-1:0] : '0;
			res.table_value <= tbl_hit ? wo0[TVAL_W-1:0] : '0;
			res.frame_done  <= frame_end;
			res.end_offset  <= end_n;
		end
	end

	`SRLE_ASSERT(a_data_before_end, clk, arst_n,
		res.valid && res.data_valid |-> res.end_offset == res.data_addr + ADDR_W'(1))
	`SRLE_ASSERT(a_table_is_head, clk, arst_n,
		res.valid && res.table_valid |-> res.table_value == res.head_addr[TVAL_W-1:0])
	`SRLE_ASSERT(a_data_follows_kind, clk, arst_n,
		acc |=> res.valid && (res.data_valid == !$past(pix.is_transparent)))
	`SRLE_ASSERT(a_done_rewinds, clk, arst_n,
		acc && frame_end |=> col_q == '0 && row_q == '0)
endmodule
